// ===== sv/kwlex_pkg.sv =====
// kwlex_pkg: shared types, token kinds and the word table of the keyword token lexer
package kwlex_pkg;

  localparam int unsigned MAX_LINE = 4096;
  localparam int unsigned COL_W = $clog2(MAX_LINE + 1);
  localparam int unsigned START_W = $clog2(MAX_LINE);
  localparam int unsigned WORD_ENTRIES = 45;
  localparam int unsigned WORD_MAX = 22;
  localparam int unsigned WORD_TXT_W = WORD_MAX * 8;
  localparam logic [4:0] WSIZE_NONE = 5'd31;

  localparam logic [15:0] CYR_BASE = 16'h0430;
  localparam logic [15:0] CYR_LO_A = 16'h0430;
  localparam logic [15:0] CYR_LO_Z = 16'h044F;
  localparam logic [15:0] CYR_UP_A = 16'h0410;
  localparam logic [15:0] CYR_UP_Z = 16'h042F;
  localparam logic [15:0] YO_LO = 16'h0451;
  localparam logic [15:0] YO_UP = 16'h0401;
  localparam logic [15:0] CH_QUOTE = 16'h0022;
  localparam logic [15:0] CH_HASH = 16'h0023;
  localparam logic [15:0] CH_AMP = 16'h0026;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_SLASH = 16'h002F;
  localparam logic [15:0] CH_DOT = 16'h002E;
  localparam logic [15:0] CH_COMMA = 16'h002C;
  localparam logic [15:0] CH_UNDER = 16'h005F;
  localparam logic [15:0] CH_0 = 16'h0030;
  localparam logic [15:0] CH_9 = 16'h0039;
  localparam logic [15:0] CH_UA = 16'h0041;
  localparam logic [15:0] CH_UZ = 16'h005A;
  localparam logic [15:0] CH_LA = 16'h0061;
  localparam logic [15:0] CH_LZ = 16'h007A;

  localparam logic [3:0] K_SPACE = 4'd0;
  localparam logic [3:0] K_COMMENT = 4'd1;
  localparam logic [3:0] K_STRING = 4'd2;
  localparam logic [3:0] K_NUMBER = 4'd3;
  localparam logic [3:0] K_DIRECT = 4'd4;
  localparam logic [3:0] K_ANNOT = 4'd5;
  localparam logic [3:0] K_KEYWORD = 4'd6;
  localparam logic [3:0] K_IDENT = 4'd7;
  localparam logic [3:0] K_SYMBOL = 4'd8;

  typedef enum logic [1:0] {
    LK_NONE = 2'd0,
    LK_KEY  = 2'd1,
    LK_ANN  = 2'd2
  } lookup_e;

  typedef struct packed {
    logic [15:0] char_code;
    logic        line_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [11:0] token_start;
    logic [12:0] token_length;
    logic        line_done;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [3:0]              kind;
    lookup_e                 lookup;
    logic [WORD_ENTRIES-1:0] cand;
    logic [4:0]              wsize;
    logic [11:0]             start;
    logic [12:0]             length;
    logic                    line_done;
    logic                    last_result;
  } tok_rec_t;

  // letters as offsets from U+0430, written as '@' + offset, first letter leftmost
  localparam logic [WORD_TXT_W-1:0] WORD_TXT [WORD_ENTRIES] = '{
    "@", "B", "BNGBP@R", "B[GB@R\\HQJK^WEMHE", "B[ONKMHR\\",
    "DK_", "DN", "EQKH", "H", "HKH",
    "HM@WE", "HM@WEEQKH", "HQJK^WEMHE", "HQRHM@", "J@FDNCN",
    "JNMEVEQKH", "JNMEVONO[RJH", "JNMEVOPNVEDSP[", "JNMEVTSMJVHH", "JNMEVVHJK@",
    "KNF\\", "ME", "MENOPEDEKEMN", "MNB[I", "OEPEIRH",
    "OEPEL", "ON", "ONJ@", "ONO[RJ@", "OPEPB@R\\",
    "OPNDNKFHR\\", "OPNVEDSP@", "RNCD@", "TSMJVH_", "VHJK",
    "]JQONPR",
    "M@JKHEMRE", "M@QEPBEPE", "M@QEPBEPEAEGJNMREJQR@", "M@JKHEMREM@QEPBEPE",
    "OEPED", "ONQKE",
    "", "", ""
  };

  localparam logic [4:0] WORD_LEN [WORD_ENTRIES] = '{
    5'd1, 5'd1, 5'd7, 5'd17, 5'd9, 5'd3, 5'd2, 5'd4, 5'd1, 5'd3,
    5'd5, 5'd9, 5'd10, 5'd6, 5'd7, 5'd9, 5'd12, 5'd14, 5'd12, 5'd10,
    5'd4, 5'd2, 5'd12, 5'd5, 5'd7, 5'd5, 5'd2, 5'd4, 5'd7, 5'd8,
    5'd10, 5'd9, 5'd5, 5'd7, 5'd4, 5'd7,
    5'd9, 5'd9, 5'd21, 5'd18, 5'd5, 5'd5,
    5'd0, 5'd0, 5'd0
  };

  localparam int unsigned KEY_ENTRIES = 36;
  localparam int unsigned ANN_ENTRIES = 6;

  function automatic lookup_e word_class(int e);
    lookup_e r;
    if (e < int'(KEY_ENTRIES)) r = LK_KEY;
    else if (e < int'(KEY_ENTRIES + ANN_ENTRIES)) r = LK_ANN;
    else r = LK_NONE;
    return r;
  endfunction

  // expected code unit of table word e at position i, zero past its end
  function automatic logic [15:0] word_unit(int e, int i);
    logic [7:0] b;
    logic [15:0] r;
    r = 16'h0000;
    if (i < int'(WORD_LEN[e])) begin
      b = WORD_TXT[e][(int'(WORD_LEN[e]) - 1 - i) * 8 +: 8];
      r = CYR_BASE + {8'd0, b - 8'h40};
    end
    return r;
  endfunction

endpackage

// ===== sv/kwlex_front.sv =====
// kwlex_front: per-character lexing state machine that builds token requests
module kwlex_front #(
  parameter int unsigned WORD_BUFFER = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  kwlex_pkg::in_item_t item_i,
  output logic [1:0]          push_n_o,
  output kwlex_pkg::tok_rec_t rec0_o,
  output kwlex_pkg::tok_rec_t rec1_o
);

  localparam int unsigned WL_W = $clog2(WORD_BUFFER + 1);
  localparam int unsigned COL_W = kwlex_pkg::COL_W;
  localparam int unsigned ST_W = kwlex_pkg::START_W;
  localparam int unsigned NE = kwlex_pkg::WORD_ENTRIES;
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(kwlex_pkg::MAX_LINE);
  localparam logic [COL_W-1:0] COL_CAP = COL_W'(kwlex_pkg::MAX_LINE - 1);

  localparam logic [3:0] M_IDLE = 4'd0;
  localparam logic [3:0] M_SPACE = 4'd1;
  localparam logic [3:0] M_SLASH = 4'd2;
  localparam logic [3:0] M_COMMENT = 4'd3;
  localparam logic [3:0] M_STRING = 4'd4;
  localparam logic [3:0] M_STRQ = 4'd5;
  localparam logic [3:0] M_NUMINT = 4'd6;
  localparam logic [3:0] M_NUMFRAC = 4'd7;
  localparam logic [3:0] M_DIRECT = 4'd8;
  localparam logic [3:0] M_ANNOT = 4'd9;
  localparam logic [3:0] M_IDENT = 4'd10;

  logic [COL_W-1:0] column_q, column_d;
  logic [ST_W-1:0]  begin_q, begin_d;
  logic [3:0]       mode_q, mode_d;
  logic [NE-1:0]    cand_q, cand_d;
  logic [WL_W-1:0]  wlen_q, wlen_d;
  logic             ovf_q, ovf_d;

  logic [15:0] c, f;
  logic        last, is_space, is_digit, is_ident, cont, push, sym;
  logic [3:0]  mode_a, mode_b;
  logic [ST_W-1:0] begin_b;
  logic [COL_W-1:0] col_n;
  logic [NE-1:0]   cand_b, cand_n;
  logic [WL_W-1:0] wlen_b, wlen_n;
  logic            ovf_b, ovf_n;
  logic            a_v, b_v;
  kwlex_pkg::tok_rec_t rec_a, rec_b, rec_sym, rec_le;

  function automatic logic [3:0] mode_kind(logic [3:0] m);
    logic [3:0] k;
    unique case (m)
      M_SPACE:             k = kwlex_pkg::K_SPACE;
      M_COMMENT:           k = kwlex_pkg::K_COMMENT;
      M_STRING, M_STRQ:    k = kwlex_pkg::K_STRING;
      M_NUMINT, M_NUMFRAC: k = kwlex_pkg::K_NUMBER;
      M_DIRECT:            k = kwlex_pkg::K_DIRECT;
      M_ANNOT:             k = kwlex_pkg::K_ANNOT;
      M_IDENT:             k = kwlex_pkg::K_KEYWORD;
      default:             k = kwlex_pkg::K_SYMBOL;
    endcase
    return k;
  endfunction

  function automatic kwlex_pkg::lookup_e mode_lookup(logic [3:0] m);
    kwlex_pkg::lookup_e r;
    if (m == M_ANNOT) r = kwlex_pkg::LK_ANN;
    else if (m == M_IDENT) r = kwlex_pkg::LK_KEY;
    else r = kwlex_pkg::LK_NONE;
    return r;
  endfunction

  function automatic logic [12:0] tok_len(logic [COL_W-1:0] col, logic [ST_W-1:0] tb);
    logic [COL_W-1:0] d;
    logic [12:0] r;
    d = col - COL_W'(tb);
    if (col > COL_W'(tb)) r = (d > COL_MAX) ? 13'(COL_MAX) : 13'(d);
    else r = 13'd1;
    return r;
  endfunction

  function automatic logic [4:0] word_size(logic [WL_W-1:0] wl, logic ov);
    logic [4:0] r;
    if (ov || wl > WL_W'(kwlex_pkg::WORD_MAX)) r = kwlex_pkg::WSIZE_NONE;
    else r = wl[4:0];
    return r;
  endfunction

  assign c = item_i.char_code;
  assign last = item_i.line_end;
  assign is_space = c <= kwlex_pkg::CH_SPACE;
  assign is_digit = c >= kwlex_pkg::CH_0 && c <= kwlex_pkg::CH_9;
  assign is_ident = c == kwlex_pkg::CH_UNDER || is_digit
                 || (c >= kwlex_pkg::CH_LA && c <= kwlex_pkg::CH_LZ)
                 || (c >= kwlex_pkg::CH_UA && c <= kwlex_pkg::CH_UZ)
                 || (c >= kwlex_pkg::CYR_UP_A && c <= kwlex_pkg::CYR_LO_Z)
                 || c == kwlex_pkg::YO_LO || c == kwlex_pkg::YO_UP;

  always_comb begin
    if ((c >= kwlex_pkg::CH_UA && c <= kwlex_pkg::CH_UZ)
        || (c >= kwlex_pkg::CYR_UP_A && c <= kwlex_pkg::CYR_UP_Z)) begin
      f = c + 16'h0020;
    end else if (c == kwlex_pkg::YO_UP) begin
      f = kwlex_pkg::YO_LO;
    end else begin
      f = c;
    end
  end

  always_comb begin
    cont = 1'b0;
    mode_a = mode_q;
    unique case (mode_q)
      M_SPACE:   cont = is_space;
      M_SLASH: begin
        cont = c == kwlex_pkg::CH_SLASH;
        if (cont) mode_a = M_COMMENT;
      end
      M_COMMENT: cont = 1'b1;
      M_STRING: begin
        cont = 1'b1;
        if (c == kwlex_pkg::CH_QUOTE) mode_a = M_STRQ;
      end
      M_STRQ: begin
        cont = c == kwlex_pkg::CH_QUOTE;
        if (cont) mode_a = M_STRING;
      end
      M_NUMINT: begin
        cont = is_digit || c == kwlex_pkg::CH_DOT || c == kwlex_pkg::CH_COMMA;
        if (cont && !is_digit) mode_a = M_NUMFRAC;
      end
      M_NUMFRAC: cont = is_digit;
      M_DIRECT:  cont = is_ident;
      M_ANNOT, M_IDENT: cont = is_ident;
      default:   cont = 1'b0;
    endcase
  end

  always_comb begin
    sym = 1'b0;
    mode_b = mode_a;
    begin_b = begin_q;
    if (!cont) begin
      begin_b = (column_q < COL_CAP) ? ST_W'(column_q) : ST_W'(COL_CAP);
      priority if (is_space) mode_b = M_SPACE;
      else if (c == kwlex_pkg::CH_SLASH) mode_b = M_SLASH;
      else if (c == kwlex_pkg::CH_QUOTE) mode_b = M_STRING;
      else if (is_digit) mode_b = M_NUMINT;
      else if (c == kwlex_pkg::CH_HASH) mode_b = M_DIRECT;
      else if (c == kwlex_pkg::CH_AMP) mode_b = M_ANNOT;
      else if (is_ident) mode_b = M_IDENT;
      else begin
        mode_b = M_IDLE;
        sym = 1'b1;
      end
    end
  end

  assign push = (cont && (mode_q == M_ANNOT || mode_q == M_IDENT))
             || (!cont && mode_b == M_IDENT);

  always_comb begin
    if (cont) begin
      cand_b = cand_q;
      wlen_b = wlen_q;
      ovf_b = ovf_q;
    end else begin
      cand_b = '1;
      wlen_b = '0;
      ovf_b = 1'b0;
    end
    cand_n = cand_b;
    wlen_n = wlen_b;
    ovf_n = ovf_b;
    if (push) begin
      if (wlen_b < WL_W'(WORD_BUFFER)) begin
        for (int e = 0; e < int'(NE); e++) begin
          cand_n[e] = cand_b[e] && (f == kwlex_pkg::word_unit(e, int'(wlen_b)));
        end
        wlen_n = wlen_b + 1'b1;
      end else begin
        ovf_n = 1'b1;
      end
    end
  end

  assign col_n = (column_q < COL_MAX) ? column_q + 1'b1 : column_q;

  always_comb begin
    rec_a.kind = mode_kind(mode_q);
    rec_a.lookup = mode_lookup(mode_q);
    rec_a.cand = cand_q;
    rec_a.wsize = word_size(wlen_q, ovf_q);
    rec_a.start = begin_q;
    rec_a.length = tok_len(column_q, begin_q);
    rec_a.line_done = 1'b0;
    rec_a.last_result = 1'b0;

    rec_sym.kind = kwlex_pkg::K_SYMBOL;
    rec_sym.lookup = kwlex_pkg::LK_NONE;
    rec_sym.cand = cand_n;
    rec_sym.wsize = kwlex_pkg::WSIZE_NONE;
    rec_sym.start = begin_b;
    rec_sym.length = 13'd1;
    rec_sym.line_done = 1'b0;
    rec_sym.last_result = 1'b0;

    rec_le.kind = mode_kind(mode_b);
    rec_le.lookup = mode_lookup(mode_b);
    rec_le.cand = cand_n;
    rec_le.wsize = word_size(wlen_n, ovf_n);
    rec_le.start = begin_b;
    rec_le.length = tok_len(col_n, begin_b);
    rec_le.line_done = 1'b0;
    rec_le.last_result = 1'b0;
  end

  assign a_v = !cont && mode_q != M_IDLE;
  assign b_v = sym || (last && mode_b != M_IDLE);

  always_comb begin
    rec_b = sym ? rec_sym : rec_le;
    rec_b.line_done = last;
    rec_b.last_result = 1'b1;
    if (a_v && b_v) begin
      rec0_o = rec_a;
      rec1_o = rec_b;
    end else if (a_v) begin
      rec0_o = rec_a;
      rec0_o.line_done = last;
      rec0_o.last_result = 1'b1;
      rec1_o = rec_b;
    end else begin
      rec0_o = rec_b;
      rec1_o = rec_b;
    end
    push_n_o = accept_i ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
  end

  always_comb begin
    column_d = column_q;
    begin_d = begin_q;
    mode_d = mode_q;
    cand_d = cand_q;
    wlen_d = wlen_q;
    ovf_d = ovf_q;
    if (accept_i) begin
      cand_d = cand_n;
      if (last) begin
        column_d = '0;
        begin_d = '0;
        mode_d = M_IDLE;
        wlen_d = '0;
        ovf_d = 1'b0;
      end else begin
        column_d = col_n;
        begin_d = begin_b;
        mode_d = mode_b;
        wlen_d = wlen_n;
        ovf_d = ovf_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      begin_q <= '0;
      mode_q <= M_IDLE;
      wlen_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      column_q <= column_d;
      begin_q <= begin_d;
      mode_q <= mode_d;
      wlen_q <= wlen_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
  end

endmodule

// ===== sv/kwlex_queue.sv =====
// kwlex_queue: four-entry token request queue, two writes and one read per cycle
module kwlex_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_n_i,
  input  kwlex_pkg::tok_rec_t rec0_i,
  input  kwlex_pkg::tok_rec_t rec1_i,
  input  logic                pop_i,
  output logic                room_o,
  output logic                head_valid_o,
  output kwlex_pkg::tok_rec_t head_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW = $clog2(DEPTH);

  kwlex_pkg::tok_rec_t mem_q [DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic [PW-1:0] wp1;

  assign wp1 = wp_q + 1'b1;
  assign room_o = cnt_q <= (PW + 1)'(DEPTH - 2);
  assign head_valid_o = cnt_q != '0;
  assign head_o = mem_q[rp_q];

  always_comb begin
    wp_d = wp_q + PW'(push_n_i);
    rp_d = pop_i ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (PW + 1)'(push_n_i) - (PW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[wp_q] <= rec0_i;
    if (push_n_i == 2'd2) mem_q[wp1] <= rec1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== sv/kwlex_back.sv =====
// kwlex_back: word table resolution and the registered result stage
module kwlex_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  kwlex_pkg::tok_rec_t  head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output kwlex_pkg::out_item_t out_data_o
);

  localparam int unsigned NE = kwlex_pkg::WORD_ENTRIES;

  logic                 valid_q, valid_d, load;
  kwlex_pkg::out_item_t data_q, data_d;
  logic [NE-1:0]        hit;
  logic                 known;

  always_comb begin
    for (int e = 0; e < int'(NE); e++) begin
      hit[e] = head_i.cand[e] && head_i.wsize == kwlex_pkg::WORD_LEN[e]
            && kwlex_pkg::word_class(e) == head_i.lookup;
    end
    known = |hit;
  end

  assign load = !valid_q || !out_stall_i;
  assign pop_o = load && head_valid_i;

  always_comb begin
    data_d.token_start = head_i.start;
    data_d.token_length = head_i.length;
    data_d.line_done = head_i.line_done;
    data_d.last_result = head_i.last_result;
    unique case (head_i.lookup)
      kwlex_pkg::LK_KEY: data_d.token_kind = known ? kwlex_pkg::K_KEYWORD : kwlex_pkg::K_IDENT;
      kwlex_pkg::LK_ANN: data_d.token_kind = known ? kwlex_pkg::K_ANNOT : kwlex_pkg::K_SYMBOL;
      default:           data_d.token_kind = head_i.kind;
    endcase
    valid_d = load ? head_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o = data_q;

endmodule

// ===== sv/keyword_token_lexer.sv =====
// keyword_token_lexer: top level, lexing front, token queue and resolving back
//
//   channel | direction | payload               | handshake
//   in      | input     | char_code, line_end   | in_valid_i / in_stall_o
//   out     | output    | kind, start, length,  | out_valid_o / out_stall_i
//           |           | line_done, last_result|
//
// one character per cycle while the four-entry token queue has room for two requests
// an item closing a token and forming a symbol (or ending the line) yields two results,
// which leave the output register one after the other
// a result passes through the token queue and then the output register; no clearing pass after reset
// a stall on the output lets requests gather in the queue, which raises in_stall_o once it holds more than two
module keyword_token_lexer #(
  parameter int unsigned WORD_BUFFER = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  kwlex_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output kwlex_pkg::out_item_t out_data_o
);

  logic                accept, room, pop, head_valid;
  logic [1:0]          push_n;
  kwlex_pkg::tok_rec_t rec0, rec1, head;

  assign in_stall_o = !room;
  assign accept = in_valid_i && room;

  kwlex_front #(
    .WORD_BUFFER(WORD_BUFFER)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .push_n_o (push_n),
    .rec0_o   (rec0),
    .rec1_o   (rec1)
  );

  kwlex_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_n_i     (push_n),
    .rec0_i       (rec0),
    .rec1_i       (rec1),
    .pop_i        (pop),
    .room_o       (room),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  kwlex_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_done |-> out_data_o.last_result)
    else $error("line_done without last_result");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.token_length != 13'd0
                 && out_data_o.token_length <= 13'(kwlex_pkg::MAX_LINE))
    else $error("token length out of range");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.token_kind <= kwlex_pkg::K_SYMBOL)
    else $error("token kind out of range");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("queue popped while empty");
`endif

endmodule
